>>> rtl/fic_pkg.sv
// ----------------------------------------------------------------------------
// fic_pkg
// Shared types and constants of the fraction interval classifier: field
// widths, register indexes, item codes, chain token types and divider states.
// ----------------------------------------------------------------------------
package fic_pkg;

    // fixed field widths
    localparam int FUNC_W        = 1;
    localparam int CLASS_IDX_W   = 4;
    localparam int GROUP_IDX_W   = 3;
    localparam int BOUND_W       = 17;
    localparam int MASS_W        = 32;
    localparam int CLASS_ID_W    = 5;
    localparam int NUM_CLASSES_W = 5;
    localparam int NUM_GROUPS_W  = 4;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLASSES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_GROUPS  = 2'd1;

    localparam logic [NUM_CLASSES_W-1:0] NUM_CLASSES_RST = 5'd16;
    localparam logic [NUM_GROUPS_W-1:0]  NUM_GROUPS_RST  = 4'd8;

    // item codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 1'b1;

    // control part of a token moving along the cell chain
    typedef struct packed {
        logic valid;    // slot holds a transaction
        logic is_wr;    // bounds write, else mass sample
        logic live;     // write in range / sample of a group in use
        logic last;     // final sample of the cell
        logic found;    // some earlier class already matched every group
    } fic_tok_t;

    // payload part of a token
    typedef struct packed {
        logic [CLASS_IDX_W-1:0] class_index;
        logic [BOUND_W-1:0]     bound_low;
        logic [BOUND_W-1:0]     bound_high;
        logic [CLASS_ID_W-1:0]  class_id;
    } fic_pay_t;

    // divider sequencer states
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } fic_div_state_t;

endpackage

>>> rtl/fic_if.sv
// ----------------------------------------------------------------------------
// fic_if
// Valid/ready channels of the fraction interval classifier: sample input,
// result output and configuration write.
// ----------------------------------------------------------------------------
interface fic_in_if;
    logic                               valid;
    logic                               ready;
    logic [fic_pkg::FUNC_W-1:0]         func;
    logic [fic_pkg::CLASS_IDX_W-1:0]    class_index;
    logic [fic_pkg::GROUP_IDX_W-1:0]    group_index;
    logic [fic_pkg::BOUND_W-1:0]        bound_low;
    logic [fic_pkg::BOUND_W-1:0]        bound_high;
    logic [fic_pkg::MASS_W-1:0]         cell_mass;
    logic [fic_pkg::MASS_W-1:0]         part_mass;
    logic                               last_group;

    modport source (
        output valid, func, class_index, group_index, bound_low, bound_high,
               cell_mass, part_mass, last_group,
        input  ready
    );
    modport sink (
        input  valid, func, class_index, group_index, bound_low, bound_high,
               cell_mass, part_mass, last_group,
        output ready
    );
endinterface

interface fic_out_if;
    logic                               valid;
    logic                               ready;
    logic [fic_pkg::CLASS_ID_W-1:0]     class_id;
    logic                               matched;

    modport source (
        output valid, class_id, matched,
        input  ready
    );
    modport sink (
        input  valid, class_id, matched,
        output ready
    );
endinterface

interface fic_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [fic_pkg::CFG_IDX_W-1:0]      index;
    logic [fic_pkg::CFG_DATA_W-1:0]     data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> rtl/fraction_interval_classifier_core.sv
// ----------------------------------------------------------------------------
// fraction_interval_classifier_core
// Classifies a cell by the fractions of its group masses: a divider forms
// each group's fraction of the total, and a chain of class cells tests it
// against the stored bounds and reports the first class matching all groups.
// ----------------------------------------------------------------------------
// latency: a final sample's result passes through the divider, one stage per
// class and the output register before it is valid
// throughput: a new mass sample is taken only once the radix-2 divider is idle;
// bounds writes one per cycle while the divider is idle and the output is not stalled
// reset: num_classes 16, num_groups 8, all match bits set; bounds not cleared
module fraction_interval_classifier_core #(
    parameter int MAX_CLASSES = 16,
    parameter int MAX_GROUPS  = 8,
    parameter int FRAC_BITS   = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    fic_in_if.sink     sample,
    fic_out_if.source  result,
    fic_cfg_if.sink    cfg
);

    localparam int NCW = $clog2(MAX_CLASSES + 1);
    localparam int NGW = $clog2(MAX_GROUPS + 1);
    localparam int GW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

    logic [fic_pkg::NUM_CLASSES_W-1:0] num_classes_reg;
    logic [fic_pkg::NUM_GROUPS_W-1:0]  num_groups_reg;
    logic [NCW-1:0]                    nc_eff;
    logic [NGW-1:0]                    ng_eff;

    logic en;
    logic in_fire;
    logic wr_fire;
    logic smp_fire;
    logic div_idle;
    logic div_done;
    logic [FRAC_BITS:0] div_quot;

    logic          smp_live_reg;
    logic          smp_last_reg;
    logic [GW-1:0] smp_grp_reg;

    fic_pkg::fic_tok_t  tok_head;
    fic_pkg::fic_pay_t  pay_head;
    logic [FRAC_BITS:0] frac_head;
    logic [GW-1:0]      grp_head;

    fic_pkg::fic_tok_t  tok_chain  [0:MAX_CLASSES];
    fic_pkg::fic_pay_t  pay_chain  [0:MAX_CLASSES];
    logic [FRAC_BITS:0] frac_chain [0:MAX_CLASSES];
    logic [GW-1:0]      grp_chain  [0:MAX_CLASSES];

    fic_pkg::fic_tok_t tok_end;
    fic_pkg::fic_pay_t pay_end;
    logic              res_fire;

    logic                           out_valid_reg, out_valid_next;
    logic [fic_pkg::CLASS_ID_W-1:0] class_id_reg, class_id_next;
    logic                           matched_reg, matched_next;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_classes_reg <= fic_pkg::NUM_CLASSES_RST;
            num_groups_reg  <= fic_pkg::NUM_GROUPS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                fic_pkg::CFG_NUM_CLASSES:
                    num_classes_reg <= cfg.data[fic_pkg::NUM_CLASSES_W-1:0];
                fic_pkg::CFG_NUM_GROUPS:
                    num_groups_reg <= cfg.data[fic_pkg::NUM_GROUPS_W-1:0];
                default: ;
            endcase
        end
    end

    // effective counts, saturated to the supported range
    always_comb
    begin
        if (num_classes_reg == '0)
            nc_eff = NCW'(1);
        else if (int'(num_classes_reg) > MAX_CLASSES)
            nc_eff = NCW'(MAX_CLASSES);
        else
            nc_eff = NCW'(num_classes_reg);

        if (num_groups_reg == '0)
            ng_eff = NGW'(1);
        else if (int'(num_groups_reg) > MAX_GROUPS)
            ng_eff = NGW'(MAX_GROUPS);
        else
            ng_eff = NGW'(num_groups_reg);
    end

    // chain advances unless a held result is not taken
    assign en = !out_valid_reg || result.ready;

    // input acceptance
    assign sample.ready = div_idle && en;
    assign in_fire      = sample.valid && sample.ready;
    assign wr_fire      = in_fire && (sample.func == fic_pkg::FUNC_WRITE);
    assign smp_fire     = in_fire && (sample.func == fic_pkg::FUNC_SAMPLE);

    fic_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (smp_fire),
        .take  (en),
        .total (sample.cell_mass),
        .part  (sample.part_mass),
        .idle  (div_idle),
        .done  (div_done),
        .quot  (div_quot)
    );

    // sample side information held while dividing
    always_ff @(posedge clk)
    begin
        if (smp_fire)
        begin
            smp_live_reg <= (int'(sample.group_index) < int'(ng_eff));
            smp_last_reg <= sample.last_group;
            smp_grp_reg  <= GW'(sample.group_index);
        end
    end

    // chain head: a bounds write or a finished sample
    always_comb
    begin
        tok_head  = '0;
        pay_head  = '0;
        frac_head = div_quot;
        grp_head  = smp_grp_reg;
        if (wr_fire)
        begin
            tok_head.valid       = 1'b1;
            tok_head.is_wr       = 1'b1;
            tok_head.live        = (int'(sample.group_index) < MAX_GROUPS);
            pay_head.class_index = sample.class_index;
            pay_head.bound_low   = sample.bound_low;
            pay_head.bound_high  = sample.bound_high;
            grp_head             = GW'(sample.group_index);
        end
        else if (div_done)
        begin
            tok_head.valid = 1'b1;
            tok_head.live  = smp_live_reg;
            tok_head.last  = smp_last_reg;
        end
    end

    assign tok_chain[0]  = tok_head;
    assign pay_chain[0]  = pay_head;
    assign frac_chain[0] = frac_head;
    assign grp_chain[0]  = grp_head;

    // one cell per class
    for (genvar c = 0; c < MAX_CLASSES; c++)
    begin : g_cell
        fic_cell #(
            .CELL_ID    (c),
            .MAX_GROUPS (MAX_GROUPS),
            .FRAC_BITS  (FRAC_BITS),
            .NCW        (NCW),
            .GW         (GW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .nc_eff   (nc_eff),
            .tok_in   (tok_chain[c]),
            .pay_in   (pay_chain[c]),
            .frac_in  (frac_chain[c]),
            .grp_in   (grp_chain[c]),
            .tok_out  (tok_chain[c+1]),
            .pay_out  (pay_chain[c+1]),
            .frac_out (frac_chain[c+1]),
            .grp_out  (grp_chain[c+1])
        );
    end

    // result of a final sample leaving the chain
    assign tok_end  = tok_chain[MAX_CLASSES];
    assign pay_end  = pay_chain[MAX_CLASSES];
    assign res_fire = en && tok_end.valid && !tok_end.is_wr && tok_end.last;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        class_id_next  = class_id_reg;
        matched_next   = matched_reg;
        if (res_fire)
        begin
            out_valid_next = 1'b1;
            if (ng_eff == NGW'(1))
            begin
                class_id_next = '0;
                matched_next  = 1'b1;
            end
            else if (tok_end.found)
            begin
                class_id_next = pay_end.class_id;
                matched_next  = 1'b1;
            end
            else
            begin
                class_id_next = fic_pkg::CLASS_ID_W'(nc_eff);
                matched_next  = 1'b0;
            end
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        class_id_reg <= class_id_next;
        matched_reg  <= matched_next;
    end

    assign result.valid    = out_valid_reg;
    assign result.class_id = class_id_reg;
    assign result.matched  = matched_reg;

endmodule

>>> rtl/fic_div.sv
// ----------------------------------------------------------------------------
// fic_div
// Radix-2 restoring divider forming floor(part * 2^FRAC_BITS / total),
// zero for a zero total, saturated at 2^(FRAC_BITS+1)-1. One quotient bit
// per cycle; the result is held until taken.
// ----------------------------------------------------------------------------
module fic_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           take,
    input  logic [fic_pkg::MASS_W-1:0]     total,
    input  logic [fic_pkg::MASS_W-1:0]     part,
    output logic                           idle,
    output logic                           done,
    output logic [FRAC_BITS:0]             quot
);

    localparam int MW   = fic_pkg::MASS_W;
    localparam int CNTW = $clog2(FRAC_BITS + 1);

    fic_pkg::fic_div_state_t state_reg, state_next;

    logic [CNTW-1:0]    cnt_reg, cnt_next;
    logic [MW-1:0]      div_reg, div_next;
    logic [MW:0]        rem_reg, rem_next;
    logic [FRAC_BITS:0] quot_reg, quot_next;

    logic        total_zero;
    logic        part_ge;
    logic        part_sat;
    logic [MW:0] rem_shift;
    logic        step_ge;

    // start checks: zero divisor, saturation, leading quotient bit
    assign total_zero = (total == '0);
    assign part_ge    = (part >= total);
    assign part_sat   = ({1'b0, part} >= {total, 1'b0});

    // one restoring step; the remainder stays below the divisor
    assign rem_shift = {rem_reg[MW-1:0], 1'b0};
    assign step_ge   = (rem_shift >= {1'b0, div_reg});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fic_pkg::DIV_IDLE:
            begin
                if (start)
                begin
                    if (total_zero || part_sat)
                        state_next = fic_pkg::DIV_DONE;
                    else
                        state_next = fic_pkg::DIV_RUN;
                end
            end
            fic_pkg::DIV_RUN:
            begin
                if (cnt_reg == CNTW'(1))
                    state_next = fic_pkg::DIV_DONE;
            end
            fic_pkg::DIV_DONE:
            begin
                if (take)
                    state_next = fic_pkg::DIV_IDLE;
            end
            default: state_next = fic_pkg::DIV_IDLE;
        endcase
    end

    // status outputs
    always_comb
    begin
        idle = 1'b0;
        done = 1'b0;
        case (state_reg)
            fic_pkg::DIV_IDLE: idle = 1'b1;
            fic_pkg::DIV_DONE: done = 1'b1;
            default:
            begin
                idle = 1'b0;
                done = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        cnt_next  = cnt_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if ((state_reg == fic_pkg::DIV_IDLE) && start)
        begin
            div_next = total;
            cnt_next = CNTW'(FRAC_BITS);
            if (total_zero)
                quot_next = '0;
            else if (part_sat)
                quot_next = '1;
            else
                quot_next = (FRAC_BITS + 1)'(part_ge);
            rem_next = part_ge ? {1'b0, part - total} : {1'b0, part};
        end
        else if (state_reg == fic_pkg::DIV_RUN)
        begin
            cnt_next  = cnt_reg - CNTW'(1);
            quot_next = {quot_reg[FRAC_BITS-1:0], step_ge};
            rem_next  = step_ge ? (rem_shift - {1'b0, div_reg}) : rem_shift;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fic_pkg::DIV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign quot = quot_reg;

endmodule

>>> rtl/fic_cell.sv
// ----------------------------------------------------------------------------
// fic_cell
// One class of the chain: holds this class's low and high bounds for every
// group and its match bit, applies passing bounds writes and samples, and
// forwards every token to the next class one stage later.
// ----------------------------------------------------------------------------
module fic_cell #(
    parameter int CELL_ID    = 0,
    parameter int MAX_GROUPS = 8,
    parameter int FRAC_BITS  = 16,
    parameter int NCW        = 5,
    parameter int GW         = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic [NCW-1:0]      nc_eff,
    input  fic_pkg::fic_tok_t   tok_in,
    input  fic_pkg::fic_pay_t   pay_in,
    input  logic [FRAC_BITS:0]  frac_in,
    input  logic [GW-1:0]       grp_in,
    output fic_pkg::fic_tok_t   tok_out,
    output fic_pkg::fic_pay_t   pay_out,
    output logic [FRAC_BITS:0]  frac_out,
    output logic [GW-1:0]       grp_out
);

    localparam int BW = fic_pkg::BOUND_W;
    localparam int CW = (FRAC_BITS + 1 > BW) ? FRAC_BITS + 1 : BW;

    logic [BW-1:0] low_mem  [0:MAX_GROUPS-1];
    logic [BW-1:0] high_mem [0:MAX_GROUPS-1];

    logic match_reg, match_next;

    fic_pkg::fic_tok_t  tok_reg, tok_next;
    fic_pkg::fic_pay_t  pay_reg, pay_next;
    logic [FRAC_BITS:0] frac_reg;
    logic [GW-1:0]      grp_reg;

    logic          active;
    logic          is_sample;
    logic          wr_hit;
    logic [CW-1:0] frac_w;
    logic [CW-1:0] low_w;
    logic [CW-1:0] high_w;
    logic          above;
    logic          in_range;
    logic          match_new;

    assign active    = (CELL_ID < int'(nc_eff));
    assign is_sample = tok_in.valid && !tok_in.is_wr;
    assign wr_hit    = tok_in.valid && tok_in.is_wr && tok_in.live
                       && (int'(pay_in.class_index) == CELL_ID);

    // interval test: open below unless the low bound is zero
    assign frac_w   = CW'(frac_in);
    assign low_w    = CW'(low_mem[grp_in]);
    assign high_w   = CW'(high_mem[grp_in]);
    assign above    = (low_w != '0) ? (frac_w > low_w) : 1'b1;
    assign in_range = above && (frac_w <= high_w);

    // match bit update and first-match search
    always_comb
    begin
        match_new = match_reg;
        if (is_sample && tok_in.live && active)
            match_new = match_reg & in_range;

        match_next = match_reg;
        if (is_sample)
            match_next = tok_in.last ? 1'b1 : match_new;

        tok_next = tok_in;
        pay_next = pay_in;
        if (is_sample && tok_in.last && !tok_in.found && active && match_new)
        begin
            tok_next.found   = 1'b1;
            pay_next.class_id = fic_pkg::CLASS_ID_W'(CELL_ID);
        end
    end

    // bounds storage
    always_ff @(posedge clk)
    begin
        if (en && wr_hit)
        begin
            low_mem[grp_in]  <= pay_in.bound_low;
            high_mem[grp_in] <= pay_in.bound_high;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b1;
            tok_reg   <= '0;
        end
        else if (en)
        begin
            match_reg <= match_next;
            tok_reg   <= tok_next;
        end
    end

    // forwarded payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay_reg  <= pay_next;
            frac_reg <= frac_in;
            grp_reg  <= grp_in;
        end
    end

    assign tok_out  = tok_reg;
    assign pay_out  = pay_reg;
    assign frac_out = frac_reg;
    assign grp_out  = grp_reg;

endmodule

>>> bench/tb_fraction_interval_classifier_core.sv
// ----------------------------------------------------------------------------
// tb_fraction_interval_classifier_core
// Self-checking bench for the fraction interval classifier. A queue-fed
// driver sends bounds writes and mass samples, a clocked monitor predicts each
// cell's class from its own copy of the bounds table and match vector, and
// every result is compared field by field. The run steps through several
// class/group register settings with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_fraction_interval_classifier_core;
    timeunit 1ns;
    timeprecision 1ps;

    import fic_pkg::*;

    localparam int MAX_CLASSES = 16;
    localparam int MAX_GROUPS  = 8;
    localparam int FRAC_BITS   = 16;
    localparam int TABLE_DEPTH = MAX_CLASSES * MAX_GROUPS;
    localparam logic [BOUND_W-1:0] FRAC_SAT = '1;
    localparam int LATENCY     = FRAC_BITS + MAX_CLASSES + 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 200;
    localparam int HOLD_CYCLES = 1200;
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [FUNC_W-1:0]      func;
        logic [CLASS_IDX_W-1:0] class_index;
        logic [GROUP_IDX_W-1:0] group_index;
        logic [BOUND_W-1:0]     bound_low;
        logic [BOUND_W-1:0]     bound_high;
        logic [MASS_W-1:0]      cell_mass;
        logic [MASS_W-1:0]      part_mass;
        logic                   last_group;
    } sample_item_t;

    typedef struct packed {
        logic [CLASS_ID_W-1:0] class_id;
        logic                  matched;
    } class_result_t;

    logic clk = 1'b0;
    logic rst_n;

    fic_in_if  sample_ch();
    fic_out_if result_ch();
    fic_cfg_if cfg_ch();

    fraction_interval_classifier_core #(
        .MAX_CLASSES(MAX_CLASSES),
        .MAX_GROUPS (MAX_GROUPS),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sample(sample_ch),
        .result(result_ch),
        .cfg   (cfg_ch)
    );

    // predicted block state
    logic [BOUND_W-1:0]       low_bounds  [TABLE_DEPTH];
    logic [BOUND_W-1:0]       high_bounds [TABLE_DEPTH];
    logic [MAX_CLASSES-1:0]   alive_classes;
    logic [NUM_CLASSES_W-1:0] class_count_reg;
    logic [NUM_GROUPS_W-1:0]  group_count_reg;

    sample_item_t  pending_items[$];
    class_result_t expected_classes[$];

    bit sample_taken;
    bit calm;
    int src_gap, sink_gap, hold_len;
    int src_idle_pct, sink_idle_pct;
    int queued_count, errors, reports, cycle_count;
    int writes_seen, samples_seen, hits_seen, misses_seen;

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int eff_count(int raw, int limit);
        if (raw < 1)
            return 1;
        if (raw > limit)
            return limit;
        return raw;
    endfunction

    // Q16 share of the group in the cell, saturating at FRAC_SAT, just below two
    function automatic logic [BOUND_W-1:0] q16_fraction(logic [MASS_W-1:0] total,
                                                        logic [MASS_W-1:0] part);
        longint unsigned num;
        longint unsigned q;
        if (total == '0)
            return '0;
        num = {32'd0, part};
        num = num << FRAC_BITS;
        q = num / {32'd0, total};
        if (q > {47'd0, FRAC_SAT})
            return FRAC_SAT;
        return q[BOUND_W-1:0];
    endfunction

    function automatic logic [BOUND_W-1:0] clamp_bound(int v);
        if (v < 0)
            return '0;
        if (v > int'(FRAC_SAT))
            return FRAC_SAT;
        return v[BOUND_W-1:0];
    endfunction

    // one accepted transaction: update the table or the match vector, and
    // return 1 with the class when it closes a cell
    function automatic bit classify_step(input sample_item_t it, output class_result_t res);
        logic [BOUND_W-1:0] frac;
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
        int nc;
        int ng;
        int addr;
        bit above;
        nc = eff_count(int'(class_count_reg), MAX_CLASSES);
        ng = eff_count(int'(group_count_reg), MAX_GROUPS);
        res.class_id = CLASS_ID_W'(nc);
        res.matched  = 1'b0;
        if (it.func == FUNC_WRITE)
        begin
            addr = int'(it.class_index) * MAX_GROUPS + int'(it.group_index);
            low_bounds[addr]  = it.bound_low;
            high_bounds[addr] = it.bound_high;
            return 1'b0;
        end
        if (int'(it.group_index) < ng)
        begin
            frac = q16_fraction(it.cell_mass, it.part_mass);
            for (int c = 0; c < nc; c++)
            begin
                addr  = c * MAX_GROUPS + int'(it.group_index);
                lo    = low_bounds[addr];
                hi    = high_bounds[addr];
                above = (lo != '0) ? (frac > lo) : 1'b1;
                if (!(above && frac <= hi))
                    alive_classes[c] = 1'b0;
            end
        end
        if (!it.last_group)
            return 1'b0;
        if (ng == 1)
        begin
            res.class_id = '0;
            res.matched  = 1'b1;
        end
        else
        begin
            for (int c = nc - 1; c >= 0; c--)
            begin
                if (alive_classes[c])
                begin
                    res.class_id = CLASS_ID_W'(c);
                    res.matched  = 1'b1;
                end
            end
        end
        alive_classes = '1;
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        errors++;
        if (reports < MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        reports++;
    endtask

    // input driver, changes at the falling edge
    always @(negedge clk)
    begin
        sample_item_t it;
        if (rst_n && (!sample_ch.valid || sample_taken))
        begin
            if (src_gap > 0)
            begin
                src_gap = src_gap - 1;
                sample_ch.valid <= 1'b0;
            end
            else if (pending_items.size() > 0 && $urandom_range(0, 99) < src_idle_pct)
            begin
                src_gap = $urandom_range(0, 15);
                sample_ch.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                it = pending_items.pop_front();
                sample_ch.valid       <= 1'b1;
                sample_ch.func        <= it.func;
                sample_ch.class_index <= it.class_index;
                sample_ch.group_index <= it.group_index;
                sample_ch.bound_low   <= it.bound_low;
                sample_ch.bound_high  <= it.bound_high;
                sample_ch.cell_mass   <= it.cell_mass;
                sample_ch.part_mass   <= it.part_mass;
                sample_ch.last_group  <= it.last_group;
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    // result sink: long hold-off on request, random stall bursts otherwise
    always @(negedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else if (hold_len > 0)
        begin
            hold_len = hold_len - 1;
            result_ch.ready <= 1'b0;
        end
        else if (sink_gap > 0)
        begin
            sink_gap = sink_gap - 1;
            result_ch.ready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < sink_idle_pct)
        begin
            sink_gap = $urandom_range(0, 15);
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= 1'b1;
    end

    // monitor: check results first, then predict from the accepted transaction
    always @(posedge clk)
    begin
        sample_item_t  seen;
        class_result_t want;
        class_result_t got;
        if (!rst_n)
            sample_taken <= 1'b0;
        else
        begin
            sample_taken <= sample_ch.valid && sample_ch.ready;
            if (result_ch.valid && result_ch.ready)
            begin
                got.class_id = result_ch.class_id;
                got.matched  = result_ch.matched;
                if (got.matched === 1'b1)
                    hits_seen++;
                else
                    misses_seen++;
                if (expected_classes.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result with nothing expected, %s %0d matched %0d",
                             $time, "actual class_id", got.class_id, got.matched);
                end
                else
                begin
                    want = expected_classes.pop_front();
                    if (got.class_id !== want.class_id)
                        report_mismatch("class_id", 32'(want.class_id), 32'(got.class_id));
                    if (got.matched !== want.matched)
                        report_mismatch("matched", 32'(want.matched), 32'(got.matched));
                end
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                seen.func        = sample_ch.func;
                seen.class_index = sample_ch.class_index;
                seen.group_index = sample_ch.group_index;
                seen.bound_low   = sample_ch.bound_low;
                seen.bound_high  = sample_ch.bound_high;
                seen.cell_mass   = sample_ch.cell_mass;
                seen.part_mass   = sample_ch.part_mass;
                seen.last_group  = sample_ch.last_group;
                if (seen.func == FUNC_WRITE)
                    writes_seen++;
                else
                    samples_seen++;
                if (classify_step(seen, want))
                    expected_classes.push_back(want);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_classes.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus builders
    function automatic sample_item_t random_item();
        sample_item_t it;
        it.func        = FUNC_W'($urandom);
        it.class_index = CLASS_IDX_W'($urandom);
        it.group_index = GROUP_IDX_W'($urandom);
        it.bound_low   = BOUND_W'($urandom);
        it.bound_high  = BOUND_W'($urandom);
        it.cell_mass   = $urandom;
        it.part_mass   = $urandom;
        it.last_group  = 1'($urandom);
        return it;
    endfunction

    task automatic push_write(int cls, int grp, logic [BOUND_W-1:0] lo, logic [BOUND_W-1:0] hi);
        sample_item_t it;
        it = random_item();
        it.func        = FUNC_WRITE;
        it.class_index = CLASS_IDX_W'(cls);
        it.group_index = GROUP_IDX_W'(grp);
        it.bound_low   = lo;
        it.bound_high  = hi;
        pending_items.push_back(it);
        queued_count++;
    endtask

    task automatic push_sample(int grp, logic [MASS_W-1:0] total, logic [MASS_W-1:0] part,
                               bit last);
        sample_item_t it;
        it = random_item();
        it.func        = FUNC_SAMPLE;
        it.group_index = GROUP_IDX_W'(grp);
        it.cell_mass   = total;
        it.part_mass   = part;
        it.last_group  = last;
        pending_items.push_back(it);
        queued_count++;
    endtask

    function automatic logic [MASS_W-1:0] pick_total();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r < 4)
            return $urandom_range(1, 64);
        if (r == 4)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [MASS_W-1:0] pick_part(logic [MASS_W-1:0] total);
        longint unsigned span;
        longint unsigned big;
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return total;
        // often above the total, so the fraction can saturate
        if (r < 4)
            return $urandom;
        span = {32'd0, total};
        span = span + 1;
        big = {$urandom, $urandom};
        return MASS_W'(big % span);
    endfunction

    // bounds that take or reject fraction f, with the edges hit often
    task automatic pick_bounds(input logic [BOUND_W-1:0] f, input bit hit,
                               output logic [BOUND_W-1:0] lo, output logic [BOUND_W-1:0] hi);
        int fi;
        int d;
        fi = int'(f);
        d  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 40000))
                                         : int'($urandom_range(0, 300));
        if (hit)
        begin
            case ($urandom_range(0, 3))
                0: begin lo = '0; hi = f; end
                1: begin lo = clamp_bound(fi - 1); hi = f; end
                2: begin lo = '0; hi = FRAC_SAT; end
                default: begin lo = clamp_bound(fi - d - 1); hi = clamp_bound(fi + d); end
            endcase
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            // low edge is exclusive
            lo = f;
            hi = clamp_bound(fi + d);
        end
        else
        begin
            lo = clamp_bound(fi - d - 1);
            hi = clamp_bound(fi - 1);
        end
    endtask

    // one cell, usually with bounds written so that a chosen class fits it
    task automatic queue_cell(bit broken);
        logic [MASS_W-1:0]  total;
        logic [MASS_W-1:0]  parts [MAX_GROUPS];
        logic [BOUND_W-1:0] lo;
        logic [BOUND_W-1:0] hi;
        int nc;
        int ng;
        int target;
        int spare;
        int miss_grp;
        int len;
        nc = eff_count(int'(class_count_reg), MAX_CLASSES);
        ng = eff_count(int'(group_count_reg), MAX_GROUPS);
        total = pick_total();
        for (int g = 0; g < ng; g++)
            parts[g] = pick_part(total);
        target   = $urandom_range(0, nc - 1);
        miss_grp = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ng - 1) : -1;
        if ($urandom_range(0, 9) < 7)
        begin
            for (int g = 0; g < ng; g++)
            begin
                pick_bounds(q16_fraction(total, parts[g]), g != miss_grp, lo, hi);
                push_write(target, g, lo, hi);
            end
        end
        // an earlier class opened wide wins the first-match search
        if (target > 0 && $urandom_range(0, 4) == 0)
        begin
            spare = $urandom_range(0, target - 1);
            for (int g = 0; g < ng; g++)
                push_write(spare, g, '0, FRAC_SAT);
        end
        if (!broken)
        begin
            for (int g = 0; g < ng; g++)
                push_sample(g, total, parts[g], g == ng - 1);
        end
        else
        begin
            // early end, missing end, repeated or unused groups
            len = $urandom_range(1, ng + 2);
            for (int i = 0; i < len; i++)
                push_sample($urandom_range(0, MAX_GROUPS - 1), total, pick_part(total),
                            (i == len - 1) && ($urandom_range(0, 3) != 0));
        end
    endtask

    task automatic queue_noise();
        sample_item_t it;
        logic [BOUND_W-1:0] lo;
        if ($urandom_range(0, 1) == 0)
        begin
            lo = ($urandom_range(0, 3) == 0) ? '0 : BOUND_W'($urandom);
            push_write($urandom_range(0, MAX_CLASSES - 1), $urandom_range(0, MAX_GROUPS - 1),
                       lo, BOUND_W'($urandom));
        end
        else
        begin
            it = random_item();
            it.func = FUNC_SAMPLE;
            pending_items.push_back(it);
            queued_count++;
        end
    endtask

    // every entry written before any sample can read it
    task automatic fill_bounds();
        for (int c = 0; c < MAX_CLASSES; c++)
            for (int g = 0; g < MAX_GROUPS; g++)
                push_write(c, g, ($urandom_range(0, 3) == 0) ? '0 : BOUND_W'($urandom),
                           BOUND_W'($urandom));
    endtask

    // edge cases, run with two classes and two groups
    task automatic queue_directed();
        // zero total gives fraction zero, inclusive when low is zero
        push_write(0, 0, '0, '0);
        push_write(0, 1, '0, '0);
        push_sample(0, '0, '1, 1'b0);
        push_sample(1, '0, '0, 1'b1);
        // low exclusive, high inclusive: only class 1 takes a quarter
        push_write(0, 0, 17'd16384, 17'd16384);
        push_write(1, 0, 17'd16383, 17'd16384);
        push_write(0, 1, '0, FRAC_SAT);
        push_write(1, 1, '0, FRAC_SAT);
        push_sample(0, 32'd4, 32'd1, 1'b0);
        push_sample(1, 32'd4, 32'd4, 1'b1);
        // saturated fraction at the top of the bound range
        push_write(0, 0, FRAC_SAT - 1, FRAC_SAT);
        push_sample(0, 32'd1, '1, 1'b0);
        push_sample(1, '1, '1, 1'b1);
        // no class matches; a sample of an unused group changes nothing
        push_write(0, 0, 17'd5, 17'd3);
        push_write(1, 0, 17'd5, 17'd3);
        push_sample(7, 32'd1, 32'd1, 1'b0);
        push_sample(0, 32'd100, 32'd1, 1'b0);
        push_sample(1, 32'd100, 32'd100, 1'b1);
        // a cell closed by an unused group
        push_sample(6, '0, '0, 1'b1);
    endtask

    // register writes, only while the block is idle
    task automatic set_counts(input logic [CFG_DATA_W-1:0] nc_data,
                              input logic [CFG_DATA_W-1:0] ng_data);
        logic [CFG_DATA_W-1:0] values [2];
        logic [CFG_IDX_W-1:0]  regs   [2];
        values[0] = nc_data;
        values[1] = ng_data;
        regs[0]   = CFG_NUM_CLASSES;
        regs[1]   = CFG_NUM_GROUPS;
        for (int i = 0; i < 2; i++)
        begin
            @(negedge clk);
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= regs[i];
            cfg_ch.data  <= values[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            if (regs[i] == CFG_NUM_CLASSES)
                class_count_reg = values[i];
            else
                group_count_reg = values[i][NUM_GROUPS_W-1:0];
        end
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // wait for the input side to empty, then for every expected result
    task automatic drain();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || sample_ch.valid);
        do
            @(negedge clk);
        while (expected_classes.size() != 0);
        repeat (2 * LATENCY) @(posedge clk);
    endtask

    // main sequence
    initial
    begin
        logic [CFG_DATA_W-1:0] phase_nc [NUM_PHASES];
        logic [CFG_DATA_W-1:0] phase_ng [NUM_PHASES];
        logic [CFG_DATA_W-1:0] nc_data;
        logic [CFG_DATA_W-1:0] ng_data;
        int r;
        phase_nc = '{5'd2, 5'd16, 5'd1, 5'd0, 5'd31, 5'd16, 5'd5, 5'd16};
        phase_ng = '{5'd2, 5'd8, 5'd1, 5'd16, 5'd15, 5'd1, 5'd3, 5'd8};

        rst_n                 = 1'b0;
        sample_ch.valid       = 1'b0;
        sample_ch.func        = FUNC_WRITE;
        sample_ch.class_index = '0;
        sample_ch.group_index = '0;
        sample_ch.bound_low   = '0;
        sample_ch.bound_high  = '0;
        sample_ch.cell_mass   = '0;
        sample_ch.part_mass   = '0;
        sample_ch.last_group  = 1'b0;
        result_ch.ready       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_NUM_CLASSES;
        cfg_ch.data           = '0;
        alive_classes         = '1;
        class_count_reg       = NUM_CLASSES_RST;
        group_count_reg       = NUM_GROUPS_RST;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            nc_data = phase_nc[p];
            ng_data = phase_ng[p];
            if (p == 6)
            begin
                nc_data = CFG_DATA_W'($urandom_range(2, 15));
                ng_data = CFG_DATA_W'($urandom_range(2, 7));
            end
            set_counts(nc_data, ng_data);
            @(posedge clk);
            calm          = (p == NUM_PHASES - 1);
            src_idle_pct  = (calm || p % 3 == 2) ? 0 : 10;
            sink_idle_pct = (calm || p % 3 == 1) ? 0 : 10;
            // single-group cells give a result per sample: back up the pipe
            if (p == 5)
                hold_len = HOLD_CYCLES;
            if (p == 0)
            begin
                fill_bounds();
                queue_directed();
            end
            queued_count = 0;
            while (queued_count < PHASE_ITEMS)
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    queue_cell(1'b0);
                else if (r < 80)
                    queue_cell(1'b1);
                else
                    queue_noise();
            end
            drain();
        end

        $display("run covered %0d transactions: %0d bounds writes and %0d mass samples",
                 writes_seen + samples_seen, writes_seen, samples_seen);
        $display("over %0d register settings; %0d cells classified, %0d matched, %0d not, %0d errors",
                 NUM_PHASES, hits_seen + misses_seen, hits_seen, misses_seen, errors);
        if (errors == 0 && expected_classes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
